[hw/rtl/fisr_pkg.sv]
// Package for the fast inverse square root block: binary32 constants and the
// shared normalize/round helpers used by the floating-point units.
// No dependencies.
package fisr_pkg;

	localparam logic [31:0] MAGIC_SEED       = 32'h5f3759df;
	localparam logic [31:0] CANON_NAN        = 32'h7fc00000;
	localparam logic [31:0] F_HALF           = 32'h3f000000;
	localparam logic [31:0] F_ONE_HALF       = 32'h3fc00000;
	localparam logic [30:0] MAG_INF          = 31'h7f800000;
	localparam int          NEWTON_STEPS_DEF = 3;

	// Leading zero count of a 48-bit word; 48 when the word is zero.
	function automatic logic [5:0] lzc48(input logic [47:0] p);
		logic [5:0] n;
		n = 6'd48;
		for (int i = 0; i < 48; i++) begin
			if (p[i]) n = 6'(47 - i);
		end
		return n;
	endfunction

	// Round a nonzero 48-bit magnitude to binary32 (magnitude bits only).
	// The leading one sits at bit 47-lz; e is the biased exponent it stands for.
	function automatic logic [30:0] fp_round(input logic [47:0] p, input logic [5:0] lz,
			input logic signed [10:0] e);
		logic [47:0]        s;
		logic signed [10:0] l;
		logic [10:0]        r;
		logic               lost;
		logic [7:0]         ef;
		logic               inc;
		logic [30:0]        res;
		s    = p;
		lost = 1'b0;
		ef   = 8'd0;
		r    = 11'd0;
		l    = $signed({5'd0, lz}) + e - 11'sd1;
		if (e >= 11'sd255) begin
			res = MAG_INF;
		end else begin
			if (e >= 11'sd1) begin
				s  = p << lz;
				ef = e[7:0];
			end else if (l >= 11'sd0) begin
				s = p << l[5:0];
			end else begin
				r = 11'(-l);
				if (r >= 11'd48) begin
					s    = 48'd0;
					lost = |p;
				end else begin
					s    = p >> r[5:0];
					lost = ((s << r[5:0]) != p);
				end
			end
			inc = s[23] & ((|s[22:0]) | lost | s[24]);
			// carry out of the fraction moves into the exponent field
			res = {ef, s[46:24]} + {30'd0, inc};
		end
		return res;
	endfunction

endpackage

[hw/rtl/fast_inverse_square_root.sv]
// Fast inverse square root: binary32 operand bits in, approximate 1/sqrt bits
// out. Integer seed from the magic constant, then a chain of Newton cells.
// Depends on fisr_pkg, fisr_fmul and fisr_cell.
//
// Usage:
//   Pulse start with value_bits; a transaction is taken at each clock edge with
//   start high (busy is always low, so one transaction per cycle is taken).
//   done is high for exactly one cycle with result_bits; results leave in the
//   order operands came in.
// Pipeline: three stages for the halving multiply, twelve per Newton cell
//   (four three-stage binary32 units in series), one output register.
//   Throughput: one operand per cycle.
// Every result carries round-to-nearest-even binary32 arithmetic; any NaN
//   comes out as 0x7FC00000.
// Reset clears all valid flags at once; transactions in flight are dropped.
// The receiver cannot stall, so no backpressure exists anywhere in the chain.
module fast_inverse_square_root #(
	parameter int NEWTON_STEPS = fisr_pkg::NEWTON_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] value_bits,
	output logic        done,
	output logic [31:0] result_bits
);
	import fisr_pkg::*;

	localparam int LAT = 4 + 12 * NEWTON_STEPS;

	logic [31:0] seed;
	logic        v_c [NEWTON_STEPS+1];
	logic [31:0] y_c [NEWTON_STEPS+1];
	logic [31:0] h_c [NEWTON_STEPS+1];

	assign busy = 1'b0;
	assign seed = MAGIC_SEED - {value_bits[31], value_bits[31:1]};

	fisr_fmul #(.SIDE_W(32)) u_half (
		.clk(clk), .arst_n(arst_n), .in_valid(start),
		.a(value_bits), .b(F_HALF), .side_in(seed),
		.out_valid(v_c[0]), .z(h_c[0]), .side_out(y_c[0])
	);

	for (genvar g = 0; g < NEWTON_STEPS; g++) begin : g_cell
		fisr_cell u_cell (
			.clk(clk), .arst_n(arst_n), .in_valid(v_c[g]),
			.y_in(y_c[g]), .half_in(h_c[g]),
			.out_valid(v_c[g+1]), .y_out(y_c[g+1]), .half_out(h_c[g+1])
		);
	end

	logic        done_q;
	logic [31:0] result_q;
	logic [31:0] y_last;

	assign y_last = y_c[NEWTON_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_c[NEWTON_STEPS];
		end
	end

	// canonicalize NaN; the seed alone can be a NaN when no step runs
	always_ff @(posedge clk) begin
		if ((y_last[30:23] == 8'hff) && (|y_last[22:0])) result_q <= CANON_NAN;
		else result_q <= y_last;
	end

	assign done        = done_q;
	assign result_bits = result_q;

`ifndef SYNTH
	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without a matching transaction");

	a_nan_canon: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result_bits[30:23] == 8'hff) && (|result_bits[22:0]))
		|-> (result_bits == CANON_NAN))
		else $error("non-canonical NaN on result");

	// with no Newton step the result is the bare seed, which need not be NaN
	a_nan_in: assert property (@(posedge clk) disable iff (!arst_n)
		((NEWTON_STEPS > 0) && done &&
			$past(start && (value_bits[30:23] == 8'hff) && (|value_bits[22:0]), LAT))
		|-> (result_bits == CANON_NAN))
		else $error("NaN operand did not give NaN result");
`endif

endmodule

[hw/rtl/fisr_fmul.sv]
// Three-stage binary32 multiplier (round to nearest even, subnormals kept)
// with a sideband word carried alongside. Depends on fisr_pkg.
module fisr_fmul #(
	parameter int SIDE_W = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [31:0]       a,
	input  logic [31:0]       b,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [31:0]       z,
	output logic [SIDE_W-1:0] side_out
);
	import fisr_pkg::*;

	logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	logic [23:0] ma, mb;
	logic [7:0] ea, eb;

	assign a_nan  = (a[30:23] == 8'hff) && (|a[22:0]);
	assign b_nan  = (b[30:23] == 8'hff) && (|b[22:0]);
	assign a_inf  = (a[30:23] == 8'hff) && !(|a[22:0]);
	assign b_inf  = (b[30:23] == 8'hff) && !(|b[22:0]);
	assign a_zero = (a[30:0] == 31'd0);
	assign b_zero = (b[30:0] == 31'd0);
	assign ma     = {(a[30:23] != 8'd0), a[22:0]};
	assign mb     = {(b[30:23] != 8'd0), b[22:0]};
	assign ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
	assign eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];

	logic v_s1, v_s2, v_s3;
	logic [47:0] p_s1, p_s2;
	logic signed [10:0] x_s1, e_s2;
	logic [5:0] lz_s2;
	logic sg_s1, sg_s2, nan_s1, nan_s2, inf_s1, inf_s2, zro_s1, zro_s2;
	logic [SIDE_W-1:0] sd_s1, sd_s2, sd_s3;
	logic [31:0] z_s3;
	logic [5:0] lz_w;

	assign lz_w = lzc48(p_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		p_s1   <= ma * mb;
		x_s1   <= $signed({3'd0, ea}) + $signed({3'd0, eb}) - 11'sd127;
		sg_s1  <= a[31] ^ b[31];
		nan_s1 <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
		inf_s1 <= a_inf | b_inf;
		zro_s1 <= a_zero | b_zero;
		sd_s1  <= side_in;

		p_s2   <= p_s1;
		lz_s2  <= lz_w;
		e_s2   <= x_s1 + 11'sd1 - $signed({5'd0, lz_w});
		sg_s2  <= sg_s1;
		nan_s2 <= nan_s1;
		inf_s2 <= inf_s1;
		zro_s2 <= zro_s1;
		sd_s2  <= sd_s1;

		if (nan_s2) z_s3 <= CANON_NAN;
		else if (inf_s2) z_s3 <= {sg_s2, MAG_INF};
		else if (zro_s2) z_s3 <= {sg_s2, 31'd0};
		else z_s3 <= {sg_s2, fp_round(p_s2, lz_s2, e_s2)};
		sd_s3 <= sd_s2;
	end

	assign out_valid = v_s3;
	assign z         = z_s3;
	assign side_out  = sd_s3;

endmodule

[hw/rtl/fisr_fsub.sv]
// Three-stage binary32 subtractor z = a - b (round to nearest even,
// subnormals kept) with a carried sideband word. Depends on fisr_pkg.
module fisr_fsub #(
	parameter int SIDE_W = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [31:0]       a,
	input  logic [31:0]       b,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [31:0]       z,
	output logic [SIDE_W-1:0] side_out
);
	import fisr_pkg::*;

	logic [31:0] bn, big, sml;
	logic a_nan, b_nan, a_inf, b_inf, swap;
	logic [7:0] eg, es, d;
	logic [26:0] mx, sx, sh_w, shr;

	assign bn    = {~b[31], b[30:0]};
	assign a_nan = (a[30:23] == 8'hff) && (|a[22:0]);
	assign b_nan = (b[30:23] == 8'hff) && (|b[22:0]);
	assign a_inf = (a[30:23] == 8'hff) && !(|a[22:0]);
	assign b_inf = (b[30:23] == 8'hff) && !(|b[22:0]);
	assign swap  = (bn[30:0] > a[30:0]);
	assign big   = swap ? bn : a;
	assign sml   = swap ? a : bn;
	assign eg    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
	assign es    = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
	assign d     = eg - es;
	assign mx    = {(big[30:23] != 8'd0), big[22:0], 3'b000};
	assign sx    = {(sml[30:23] != 8'd0), sml[22:0], 3'b000};
	assign shr   = sx >> d[4:0];

	// align the smaller operand, folding shifted-out bits into the sticky bit
	always_comb begin
		if (d >= 8'd27) begin
			sh_w = {26'd0, |sx};
		end else begin
			sh_w = {shr[26:1], shr[0] | ((shr << d[4:0]) != sx)};
		end
	end

	logic v_s1, v_s2, v_s3;
	logic [26:0] mx_s1, sh_s1;
	logic [7:0] eg_s1;
	logic sub_s1, sg_s1, nan_s1, inf_s1, isg_s1;
	logic [47:0] p_s2;
	logic [5:0] lz_s2;
	logic signed [10:0] e_s2;
	logic sg_s2, nan_s2, inf_s2, isg_s2, zro_s2;
	logic [SIDE_W-1:0] sd_s1, sd_s2, sd_s3;
	logic [31:0] z_s3;
	logic [27:0] sum_w;
	logic [47:0] p_w;
	logic [5:0] lz_w;

	assign sum_w = sub_s1 ? ({1'b0, mx_s1} - {1'b0, sh_s1}) : ({1'b0, mx_s1} + {1'b0, sh_s1});
	assign p_w   = {sum_w, 20'd0};
	assign lz_w  = lzc48(p_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		mx_s1  <= mx;
		sh_s1  <= sh_w;
		eg_s1  <= eg;
		sub_s1 <= big[31] ^ sml[31];
		sg_s1  <= big[31];
		nan_s1 <= a_nan | b_nan | (a_inf & b_inf & (a[31] ^ bn[31]));
		inf_s1 <= a_inf | b_inf;
		isg_s1 <= a_inf ? a[31] : bn[31];
		sd_s1  <= side_in;

		p_s2   <= p_w;
		lz_s2  <= lz_w;
		e_s2   <= $signed({3'd0, eg_s1}) + 11'sd1 - $signed({5'd0, lz_w});
		// exact cancellation gives +0; two like-signed zeros keep their sign
		sg_s2  <= (sum_w == 28'd0) ? (sg_s1 & ~sub_s1) : sg_s1;
		zro_s2 <= (sum_w == 28'd0);
		nan_s2 <= nan_s1;
		inf_s2 <= inf_s1;
		isg_s2 <= isg_s1;
		sd_s2  <= sd_s1;

		if (nan_s2) z_s3 <= CANON_NAN;
		else if (inf_s2) z_s3 <= {isg_s2, MAG_INF};
		else if (zro_s2) z_s3 <= {sg_s2, 31'd0};
		else z_s3 <= {sg_s2, fp_round(p_s2, lz_s2, e_s2)};
		sd_s3 <= sd_s2;
	end

	assign out_valid = v_s3;
	assign z         = z_s3;
	assign side_out  = sd_s3;

endmodule

[hw/rtl/fisr_cell.sv]
// One Newton refinement cell: y' = y * (1.5 - (half*y)*y), twelve stages deep.
// Depends on fisr_pkg, fisr_fmul and fisr_fsub.
module fisr_cell (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [31:0] y_in,
	input  logic [31:0] half_in,
	output logic        out_valid,
	output logic [31:0] y_out,
	output logic [31:0] half_out
);
	import fisr_pkg::*;

	logic v1, v2, v3;
	logic [31:0] hy, hyy, corr;
	logic [63:0] sd1, sd2, sd3;

	fisr_fmul #(.SIDE_W(64)) u_hy (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid),
		.a(half_in), .b(y_in), .side_in({half_in, y_in}),
		.out_valid(v1), .z(hy), .side_out(sd1)
	);

	fisr_fmul #(.SIDE_W(64)) u_hyy (
		.clk(clk), .arst_n(arst_n), .in_valid(v1),
		.a(hy), .b(sd1[31:0]), .side_in(sd1),
		.out_valid(v2), .z(hyy), .side_out(sd2)
	);

	fisr_fsub #(.SIDE_W(64)) u_corr (
		.clk(clk), .arst_n(arst_n), .in_valid(v2),
		.a(F_ONE_HALF), .b(hyy), .side_in(sd2),
		.out_valid(v3), .z(corr), .side_out(sd3)
	);

	fisr_fmul #(.SIDE_W(32)) u_y (
		.clk(clk), .arst_n(arst_n), .in_valid(v3),
		.a(sd3[31:0]), .b(corr), .side_in(sd3[63:32]),
		.out_valid(out_valid), .z(y_out), .side_out(half_out)
	);

endmodule
